>>> design/dq_pkg.sv
// shared types, constants and index helpers for the double-ended queue
package dq_pkg;

  // store geometry
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned StatW = 2;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CmdNone      = 3'd0,
    CmdPushFront = 3'd1,
    CmdPushBack  = 3'd2,
    CmdPopFront  = 3'd3,
    CmdPopBack   = 3'd4,
    CmdClear     = 3'd5
  } cmd_e;

  // status codes
  typedef enum logic [StatW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // (idx + cnt) mod Depth, valid for idx < Depth and cnt < 2*Depth - idx
  function automatic idx_t wrap_add(idx_t idx, cnt_t cnt);
    logic [SumW-1:0] sum;
    sum = SumW'(idx) + SumW'(cnt);
    if (sum >= SumW'(Depth)) begin
      sum = sum - SumW'(Depth);
    end
    return idx_t'(sum);
  endfunction

  // idx + 1 mod Depth
  function automatic idx_t idx_inc(idx_t idx);
    return (idx == idx_t'(Depth - 1)) ? '0 : idx + idx_t'(1);
  endfunction

  // idx - 1 mod Depth
  function automatic idx_t idx_dec(idx_t idx);
    return (idx == '0) ? idx_t'(Depth - 1) : idx - idx_t'(1);
  endfunction

endpackage

>>> design/dq_ram.sv
// generic ram: one write port, two registered read ports
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> design/double_ended_queue_core.sv
// double-ended queue: ring store in ram, head and count in registers
// the ram read and the payload are registered when an item is accepted; the output
// register loads the result in the load state once free, which holds off new items
// the next item is accepted while a result waits in the output register
// reset: head, count, state and output valid clear at once; the store is not cleared,
// entries outside the held range never reach the outputs
module double_ended_queue_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dq_pkg::CmdW-1:0]           command_i,
  input  logic signed [dq_pkg::DataW-1:0]   value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [dq_pkg::DataW-1:0]   front_value_o,
  output logic signed [dq_pkg::DataW-1:0]   back_value_o,
  output logic                              is_empty_o,
  output logic [dq_pkg::CntW-1:0]           occupancy_o,
  output logic [dq_pkg::StatW-1:0]          status_o
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StLoad = 2'b10
  } state_e;

  state_e     state_q, state_d;
  idx_t       head_q, head_d;
  cnt_t       count_q, count_d;
  status_e    stat_q, stat_d;
  logic       fwd_front_q, fwd_back_q;
  logic [DataW-1:0] fwd_data_q;

  logic       out_valid_q;
  logic [DataW-1:0] front_q, back_q;
  logic       empty_q;
  cnt_t       occ_q;
  status_e    out_stat_q;

  logic       accept;
  logic       out_free;
  logic       we;
  idx_t       waddr;
  idx_t       front_addr, back_addr;
  logic [DataW-1:0] rdata_a, rdata_b;
  cmd_e       cmd;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cmd      = cmd_e'(command_i);

  // command decode: next head, count, status and the store write
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    stat_d  = StatOk;
    we      = 1'b0;
    waddr   = head_q;
    case (cmd)
      CmdPushFront: begin
        if (count_q == cnt_t'(Depth)) begin
          stat_d = StatFull;
        end else begin
          head_d  = idx_dec(head_q);
          waddr   = head_d;
          we      = accept;
          count_d = count_q + cnt_t'(1);
        end
      end
      CmdPushBack: begin
        if (count_q == cnt_t'(Depth)) begin
          stat_d = StatFull;
        end else begin
          waddr   = wrap_add(head_q, count_q);
          we      = accept;
          count_d = count_q + cnt_t'(1);
        end
      end
      CmdPopFront: begin
        if (count_q == '0) begin
          stat_d = StatEmpty;
        end else begin
          head_d  = idx_inc(head_q);
          count_d = count_q - cnt_t'(1);
        end
      end
      CmdPopBack: begin
        if (count_q == '0) begin
          stat_d = StatEmpty;
        end else begin
          count_d = count_q - cnt_t'(1);
        end
      end
      CmdClear: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // read addresses of the new front and back, junk when empty
  assign front_addr = head_d;
  assign back_addr  = wrap_add(head_d, count_d - cnt_t'(1));

  dq_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (value_i),
    .re_i     (accept),
    .raddr_a_i(front_addr),
    .raddr_b_i(back_addr),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

  // per-item payload, with forwarding of a write that aliases a read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q      <= stat_d;
      fwd_front_q <= we && (waddr == front_addr);
      fwd_back_q  <= we && (waddr == back_addr);
      fwd_data_q  <= value_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StLoad && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && out_free) begin
      empty_q    <= (count_q == '0);
      occ_q      <= count_q;
      out_stat_q <= stat_q;
      if (count_q == '0) begin
        front_q <= '0;
        back_q  <= '0;
      end else begin
        front_q <= fwd_front_q ? fwd_data_q : rdata_a;
        back_q  <= fwd_back_q ? fwd_data_q : rdata_b;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign is_empty_o    = empty_q;
  assign occupancy_o   = occ_q;
  assign status_o      = out_stat_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(Depth))
    else $error("count exceeds depth");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StLoad)
    else $error("accepted item did not start a load");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StLoad))
    else $error("result appeared without a load");

  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (occupancy_o == '0)))
    else $error("empty flag disagrees with occupancy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("empty result carries data");

endmodule

>>> sim/tb_double_ended_queue_core.sv
// self-checking testbench for the double-ended queue core with its own deque predictor
module tb_double_ended_queue_core;
  import dq_pkg::*;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned RandomPerPhase = 131;
  localparam int unsigned SettleCycles   = 8;

  // a local copy of the deque and the queued snapshots the block should report after each command
  class deque_scoreboard;
    logic signed [DataW-1:0] ring_copy [Depth];
    int unsigned             head_pos;
    int unsigned             held;
    int unsigned             mismatches;
    logic signed [DataW-1:0] want_front [$];
    logic signed [DataW-1:0] want_back [$];
    logic                    want_empty [$];
    logic [CntW-1:0]         want_occ [$];
    logic [StatW-1:0]        want_status [$];

    function new();
      head_pos   = 0;
      held       = 0;
      mismatches = 0;
      foreach (ring_copy[i]) ring_copy[i] = '0;
    endfunction

    // apply one accepted command to the local deque and queue the snapshot it implies
    function void note_command(logic [CmdW-1:0] cmd, logic signed [DataW-1:0] val);
      logic [StatW-1:0] st;
      st = StatOk;
      case (cmd)
        CmdPushFront: begin
          if (held >= Depth) begin
            st = StatFull;
          end else begin
            head_pos = (head_pos + Depth - 1) % Depth;
            ring_copy[head_pos] = val;
            held++;
          end
        end
        CmdPushBack: begin
          if (held >= Depth) begin
            st = StatFull;
          end else begin
            ring_copy[(head_pos + held) % Depth] = val;
            held++;
          end
        end
        CmdPopFront: begin
          if (held == 0) begin
            st = StatEmpty;
          end else begin
            head_pos = (head_pos + 1) % Depth;
            held--;
          end
        end
        CmdPopBack: begin
          if (held == 0) begin
            st = StatEmpty;
          end else begin
            held--;
          end
        end
        CmdClear: begin
          head_pos = 0;
          held     = 0;
        end
        default: ;
      endcase
      if (held == 0) begin
        want_front.insert(want_front.size(), '0);
        want_back.insert(want_back.size(), '0);
        want_empty.insert(want_empty.size(), 1'b1);
      end else begin
        want_front.insert(want_front.size(), ring_copy[head_pos]);
        want_back.insert(want_back.size(), ring_copy[(head_pos + held + Depth - 1) % Depth]);
        want_empty.insert(want_empty.size(), 1'b0);
      end
      want_occ.insert(want_occ.size(), CntW'(held));
      want_status.insert(want_status.size(), st);
    endfunction

    function int unsigned outstanding();
      return want_status.size();
    endfunction

    function void field_check(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // compare one delivered result with the oldest queued snapshot
    function void check_result(logic signed [DataW-1:0] front, logic signed [DataW-1:0] back,
                               logic empty, logic [CntW-1:0] occ, logic [StatW-1:0] st);
      if (want_status.size() == 0) begin
        $display("%0t: result with no item pending, expected none, got front %h", $time, front);
        mismatches++;
        return;
      end
      field_check("front_value", want_front[0], front);
      field_check("back_value", want_back[0], back);
      field_check("is_empty", DataW'(want_empty[0]), DataW'(empty));
      field_check("occupancy", DataW'(want_occ[0]), DataW'(occ));
      field_check("status", DataW'(want_status[0]), DataW'(st));
      want_front.delete(0);
      want_back.delete(0);
      want_empty.delete(0);
      want_occ.delete(0);
      want_status.delete(0);
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [CmdW-1:0]         command_i   = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] front_value_o;
  logic signed [DataW-1:0] back_value_o;
  logic                    is_empty_o;
  logic [CntW-1:0]         occupancy_o;
  logic [StatW-1:0]        status_o;

  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycle_count    = 0;
  deque_scoreboard deque_sb;

  double_ended_queue_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .is_empty_o    (is_empty_o),
    .occupancy_o   (occupancy_o),
    .status_o      (status_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, deque_sb.outstanding());
      $display("** double_ended_queue_core: FAILED **");
      $finish;
    end
  end

  // result side: check each delivered item, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      deque_sb.check_result(front_value_o, back_value_o, is_empty_o, occupancy_o, status_o);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // offer one command item, with random idle cycles ahead of it
  task automatic send_command(input logic [CmdW-1:0] cmd, input logic signed [DataW-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    deque_sb.note_command(cmd, val);
  endtask

  // hold off the sender until every queued snapshot has been delivered
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (deque_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // random value, extremes now and then
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 32'sh7fffffff;
    if (roll < 16) return 32'sh80000000;
    if (roll < 20) return '0;
    if (roll < 24) return -32'sd1;
    return $urandom;
  endfunction

  // command mix that leans toward filling or toward draining, with some clears, no-ops and unused codes
  function automatic logic [CmdW-1:0] pick_command(bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return CmdClear;
    if (roll < 4) return CmdNone;
    if (roll < 6) return CmdW'($urandom_range(6, 7));
    if (roll < 66) begin
      if (filling) return ($urandom_range(0, 1) != 0) ? CmdPushFront : CmdPushBack;
      return ($urandom_range(0, 1) != 0) ? CmdPopFront : CmdPopBack;
    end
    if (filling) return ($urandom_range(0, 1) != 0) ? CmdPopFront : CmdPopBack;
    return ($urandom_range(0, 1) != 0) ? CmdPushFront : CmdPushBack;
  endfunction

  // stimulus
  initial begin
    int unsigned send_pcts [4];
    int unsigned recv_pcts [4];
    int unsigned run_left;
    bit          filling;
    send_pcts = '{0, 51, 0, 22};
    recv_pcts = '{0, 0, 51, 22};
    deque_sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pops on empty, extremes, unused codes, popping the last element
    send_command(CmdPopFront, 32'sd5);
    send_command(CmdPopBack, -32'sd5);
    send_command(CmdPushBack, 32'sh7fffffff);
    send_command(CmdPushFront, 32'sh80000000);
    send_command(CmdNone, 32'sd77);
    send_command(CmdW'(6), -32'sd1);
    send_command(CmdW'(7), 32'sh55aa55aa);
    send_command(CmdPopBack, '0);
    send_command(CmdPopFront, '0);
    // directed: fill to the limit, pushes when full, then clear
    for (int i = 0; i < Depth; i++) begin
      send_command((i % 2 == 0) ? CmdPushBack : CmdPushFront, pick_value());
    end
    send_command(CmdPushFront, 32'sd1);
    send_command(CmdPushBack, 32'sd2);
    send_command(CmdClear, -32'sd1);
    wait_all_results();

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      filling  = 1'b1;
      run_left = $urandom_range(10, 30);
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (run_left == 0) begin
          filling  = !filling;
          run_left = $urandom_range(10, 30);
        end
        run_left--;
        send_command(pick_command(filling), pick_value());
      end
      wait_all_results();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk_i);
    if (deque_sb.outstanding() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, deque_sb.outstanding());
    end
    if (deque_sb.mismatches == 0 && deque_sb.outstanding() == 0) begin
      $display("** double_ended_queue_core: PASSED **");
    end else begin
      $display("** double_ended_queue_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/dq_pkg.sv
design/dq_ram.sv
design/double_ended_queue_core.sv
sim/tb_double_ended_queue_core.sv
